@@ design/aspc_pkg.sv @@
`default_nettype none

package aspc_pkg;

  localparam int TickBits = 12;
  localparam int ElapsedW = 12;
  localparam int CmpW     = (TickBits > ElapsedW) ? TickBits : ElapsedW;
  localparam logic [TickBits-1:0] TickMax = {TickBits{1'b1}};

  localparam int CfgW    = 12;
  localparam int CfgIdxW = 3;
  localparam int LoadW   = 6;

  localparam int InDataW  = 24;
  localparam int OutDataW = 40;

  typedef enum logic [2:0] {
    PH_NS_GREEN  = 3'd0,
    PH_NS_YELLOW = 3'd1,
    PH_ALL_RED   = 3'd2,
    PH_EW_GREEN  = 3'd3,
    PH_EW_YELLOW = 3'd4,
    PH_ALL_WALK  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    REQ_NS_GREEN = 3'd0,
    REQ_EW_GREEN = 3'd1,
    REQ_ALL_RED  = 3'd2,
    REQ_ALL_WALK = 3'd3,
    REQ_WALK_H   = 3'd4,
    REQ_WALK_V   = 3'd5
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NS_MIN_GREEN = 3'd0,
    CFG_EW_MIN_GREEN = 3'd1,
    CFG_MAX_GREEN    = 3'd2,
    CFG_NS_YELLOW    = 3'd3,
    CFG_EW_YELLOW    = 3'd4,
    CFG_ALL_RED      = 3'd5,
    CFG_WALK_TIME    = 3'd6
  } cfg_idx_e;

  localparam logic [CfgW-1:0] RstNsMinGreen = 12'd100;
  localparam logic [CfgW-1:0] RstEwMinGreen = 12'd100;
  localparam logic [CfgW-1:0] RstMaxGreen   = 12'd300;
  localparam logic [CfgW-1:0] RstNsYellow   = 12'd40;
  localparam logic [CfgW-1:0] RstEwYellow   = 12'd40;
  localparam logic [CfgW-1:0] RstAllRed     = 12'd20;
  localparam logic [CfgW-1:0] RstWalkTime   = 12'd120;

endpackage

`default_nettype wire

@@ design/actuated_signal_phase_controller.sv @@
// Actuated two-axis signal controller with an all-walk scramble phase.
// Input stream (s_axis): one transfer per item. tuser[0] is the item kind
// (0 time tick, 1 manual request); tdata carries the request target,
// manual mode, both axis loads and the pedestrian flags.
// Output stream (m_axis): one transfer per input item with phase, pending
// target, ticks in phase, countdown and the walker/waiter pulses.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// clock edge; indexes past the walk time register are ignored. Write only
// while the block is idle.
// An item accepted on s_axis goes to the input register, then to the result
// register. Throughput: one item per cycle while m_axis does not stall, set
// by the single input and result registers with the phase logic between them.
// When m_axis stalls, the result register holds and the input register
// takes one more item; s_axis_tready_o drops only when both are full.
// Reset: phase and pending target go to NS green, the tick count to zero,
// timing registers to their defaults, and both stages empty.
`default_nettype none

module actuated_signal_phase_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [2:0] request_target, [3] manual_op, [9:4] ns_load, [15:10] ew_load,
  // [16] walk_wait_h, [17] walk_wait_v, [18] walkers_active,
  // [19] crossing_clear, [20] rush_on_ns, rest zero
  input  wire logic [aspc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] func
  input  wire logic [0:0]                    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [2:0] phase, [5:3] pending_phase, [17:6] phase_elapsed,
  // [29:18] countdown, [30] release_walkers, [31] add_waiter_h,
  // [32] add_waiter_v, rest zero
  output logic [aspc_pkg::OutDataW-1:0]      m_axis_tdata_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [aspc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [aspc_pkg::CfgW-1:0]     cfg_wdata_i
);

  localparam int TickBits = aspc_pkg::TickBits;
  localparam int CmpW     = aspc_pkg::CmpW;
  localparam int LoadW    = aspc_pkg::LoadW;

  // timing registers
  logic [aspc_pkg::CfgW-1:0] ns_min_q, ew_min_q, max_green_q;
  logic [aspc_pkg::CfgW-1:0] ns_yel_q, ew_yel_q, all_red_q, walk_q;

  // pipeline stages
  logic                         in_valid_q;
  logic [aspc_pkg::InDataW-1:0] in_data_q;
  logic                         in_func_q;
  logic                         out_valid_q;
  logic [aspc_pkg::OutDataW-1:0] out_data_q;
  logic                         move;

  // controller state
  aspc_pkg::phase_e      phase_q, phase_d;
  aspc_pkg::phase_e      pend_q, pend_d;
  logic [TickBits-1:0]   tick_q, tick_d;

  // unpacked item fields
  logic [2:0]       tgt;
  logic             manual, wait_h, wait_v, active, clear, rush_ns;
  logic [LoadW-1:0] ns_load, ew_load;

  logic                       rel, add_h, add_v;
  logic [aspc_pkg::ElapsedW-1:0] countdown;

  assign tgt     = in_data_q[2:0];
  assign manual  = in_data_q[3];
  assign ns_load = in_data_q[9:4];
  assign ew_load = in_data_q[15:10];
  assign wait_h  = in_data_q[16];
  assign wait_v  = in_data_q[17];
  assign active  = in_data_q[18];
  assign clear   = in_data_q[19];
  assign rush_ns = in_data_q[20];

  assign move            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || move;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_min_q    <= aspc_pkg::RstNsMinGreen;
      ew_min_q    <= aspc_pkg::RstEwMinGreen;
      max_green_q <= aspc_pkg::RstMaxGreen;
      ns_yel_q    <= aspc_pkg::RstNsYellow;
      ew_yel_q    <= aspc_pkg::RstEwYellow;
      all_red_q   <= aspc_pkg::RstAllRed;
      walk_q      <= aspc_pkg::RstWalkTime;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aspc_pkg::CFG_NS_MIN_GREEN: ns_min_q    <= cfg_wdata_i;
        aspc_pkg::CFG_EW_MIN_GREEN: ew_min_q    <= cfg_wdata_i;
        aspc_pkg::CFG_MAX_GREEN:    max_green_q <= cfg_wdata_i;
        aspc_pkg::CFG_NS_YELLOW:    ns_yel_q    <= cfg_wdata_i;
        aspc_pkg::CFG_EW_YELLOW:    ew_yel_q    <= cfg_wdata_i;
        aspc_pkg::CFG_ALL_RED:      all_red_q   <= cfg_wdata_i;
        aspc_pkg::CFG_WALK_TIME:    walk_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= aspc_pkg::PH_NS_GREEN;
      pend_q      <= aspc_pkg::PH_NS_GREEN;
      tick_q      <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (move) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        pend_q      <= pend_d;
        tick_q      <= tick_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
      in_func_q <= s_axis_tuser_i[0];
    end
    if (move) begin
      out_data_q <= {7'b0, add_v, add_h, rel, countdown,
                     aspc_pkg::ElapsedW'(tick_d), pend_d, phase_d};
    end
  end

  // next state for the item in the input register
  always_comb begin
    logic [TickBits-1:0] inc;
    logic [CmpW-1:0]     inc_w;
    logic                is_ns, past_min, scramble, yield_g;
    logic [LoadW-1:0]    own, other;
    logic [aspc_pkg::CfgW-1:0] min_g, yel_t;
    aspc_pkg::phase_e    heavier, green_t;

    phase_d = phase_q;
    pend_d  = pend_q;
    tick_d  = tick_q;
    rel     = 1'b0;
    add_h   = 1'b0;
    add_v   = 1'b0;

    inc   = (tick_q == aspc_pkg::TickMax) ? tick_q : tick_q + TickBits'(1);
    inc_w = CmpW'(inc);

    is_ns    = (phase_q == aspc_pkg::PH_NS_GREEN);
    own      = is_ns ? ns_load : ew_load;
    other    = is_ns ? ew_load : ns_load;
    min_g    = is_ns ? ns_min_q : ew_min_q;
    past_min = inc_w >= CmpW'(min_g);
    scramble = wait_h && wait_v && past_min;
    yield_g  = scramble || (past_min && ((other > own) ||
               ((other != '0) && (own == '0)) || (inc_w >= CmpW'(max_green_q))));
    yel_t    = (phase_q == aspc_pkg::PH_NS_YELLOW) ? ns_yel_q : ew_yel_q;

    if (ns_load > ew_load) begin
      heavier = aspc_pkg::PH_NS_GREEN;
    end else if (ew_load > ns_load) begin
      heavier = aspc_pkg::PH_EW_GREEN;
    end else begin
      heavier = rush_ns ? aspc_pkg::PH_NS_GREEN : aspc_pkg::PH_EW_GREEN;
    end
    green_t = (tgt == aspc_pkg::REQ_NS_GREEN) ? aspc_pkg::PH_NS_GREEN
                                               : aspc_pkg::PH_EW_GREEN;

    if (!in_func_q) begin
      tick_d = inc;
      case (phase_q)
        aspc_pkg::PH_NS_GREEN, aspc_pkg::PH_EW_GREEN: begin
          if (!manual && yield_g) begin
            phase_d = is_ns ? aspc_pkg::PH_NS_YELLOW : aspc_pkg::PH_EW_YELLOW;
            tick_d  = '0;
            if (scramble) begin
              pend_d = aspc_pkg::PH_ALL_WALK;
            end else begin
              pend_d = is_ns ? aspc_pkg::PH_EW_GREEN : aspc_pkg::PH_NS_GREEN;
            end
          end
        end
        aspc_pkg::PH_NS_YELLOW, aspc_pkg::PH_EW_YELLOW: begin
          if (inc_w >= CmpW'(yel_t)) begin
            tick_d = '0;
            if (manual && (pend_q == aspc_pkg::PH_NS_GREEN ||
                           pend_q == aspc_pkg::PH_EW_GREEN)) begin
              phase_d = pend_q;
            end else begin
              phase_d = aspc_pkg::PH_ALL_RED;
            end
          end
        end
        aspc_pkg::PH_ALL_RED: begin
          if (pend_q != aspc_pkg::PH_ALL_RED && inc_w >= CmpW'(all_red_q)) begin
            if (pend_q != aspc_pkg::PH_ALL_WALK) begin
              phase_d = pend_q;
              tick_d  = '0;
            end else if (clear) begin
              phase_d = aspc_pkg::PH_ALL_WALK;
              tick_d  = '0;
              rel     = 1'b1;
            end
          end
        end
        default: begin
          if (inc_w >= CmpW'(walk_q) && !wait_h && !wait_v && !active) begin
            phase_d = aspc_pkg::PH_ALL_RED;
            tick_d  = '0;
            pend_d  = manual ? aspc_pkg::PH_ALL_RED : heavier;
          end
        end
      endcase
    end else begin
      case (tgt)
        aspc_pkg::REQ_WALK_H: add_h = 1'b1;
        aspc_pkg::REQ_WALK_V: add_v = 1'b1;
        aspc_pkg::REQ_ALL_WALK, aspc_pkg::REQ_ALL_RED: begin
          pend_d = (tgt == aspc_pkg::REQ_ALL_WALK) ? aspc_pkg::PH_ALL_WALK
                                                   : aspc_pkg::PH_ALL_RED;
          if (phase_q == aspc_pkg::PH_NS_GREEN) begin
            phase_d = aspc_pkg::PH_NS_YELLOW;
            tick_d  = '0;
          end else if (phase_q == aspc_pkg::PH_EW_GREEN) begin
            phase_d = aspc_pkg::PH_EW_YELLOW;
            tick_d  = '0;
          end else if (phase_q == aspc_pkg::PH_ALL_RED) begin
            if (tgt == aspc_pkg::REQ_ALL_RED) begin
              tick_d = '0;
            end else if (clear) begin
              phase_d = aspc_pkg::PH_ALL_WALK;
              tick_d  = '0;
              rel     = 1'b1;
            end
          end
        end
        aspc_pkg::REQ_NS_GREEN, aspc_pkg::REQ_EW_GREEN: begin
          pend_d = green_t;
          if (phase_q == aspc_pkg::PH_NS_GREEN && green_t == aspc_pkg::PH_EW_GREEN) begin
            phase_d = aspc_pkg::PH_NS_YELLOW;
            tick_d  = '0;
          end else if (phase_q == aspc_pkg::PH_EW_GREEN &&
                       green_t == aspc_pkg::PH_NS_GREEN) begin
            phase_d = aspc_pkg::PH_EW_YELLOW;
            tick_d  = '0;
          end else if (phase_q == aspc_pkg::PH_ALL_RED) begin
            phase_d = green_t;
            tick_d  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // countdown on the updated state
  always_comb begin
    logic            hold;
    logic [aspc_pkg::CfgW-1:0] limit;
    logic [CmpW-1:0] lim_w, tick_w;

    hold = manual && (phase_d == aspc_pkg::PH_NS_GREEN || phase_d == aspc_pkg::PH_EW_GREEN ||
           (phase_d == aspc_pkg::PH_ALL_RED && pend_d == aspc_pkg::PH_ALL_RED));
    case (phase_d)
      aspc_pkg::PH_NS_GREEN:  limit = ns_min_q;
      aspc_pkg::PH_NS_YELLOW: limit = ns_yel_q;
      aspc_pkg::PH_ALL_RED:   limit = all_red_q;
      aspc_pkg::PH_EW_GREEN:  limit = ew_min_q;
      aspc_pkg::PH_EW_YELLOW: limit = ew_yel_q;
      aspc_pkg::PH_ALL_WALK:  limit = walk_q;
      default:                limit = '0;
    endcase
    lim_w  = CmpW'(limit);
    tick_w = CmpW'(tick_d);
    if (hold || !(lim_w > tick_w)) begin
      countdown = '0;
    end else begin
      countdown = aspc_pkg::ElapsedW'(lim_w - tick_w);
    end
  end

  // a release pulse only comes with the scramble phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[30] |-> out_data_q[2:0] == aspc_pkg::PH_ALL_WALK)
    else $error("release without all walk phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_data_q[31] && out_data_q[32] && out_valid_q))
    else $error("both waiter pulses set");

  // entering a phase restarts its tick count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != $past(phase_q) |-> tick_q == '0)
    else $error("phase change without tick restart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import aspc_pkg::*;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_REQ    = 1'b1;
  localparam logic MODE_AUTO   = 1'b0;
  localparam logic MODE_MANUAL = 1'b1;
  // request code with no meaning, must be ignored
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic             rush;
    logic             clr;
    logic             walkers;
    logic             wv;
    logic             wh;
    logic [LoadW-1:0] ew;
    logic [LoadW-1:0] ns;
    logic             manual;
    logic [2:0]       tgt;
  } item_fields_t;

  typedef struct packed {
    logic                add_v;
    logic                add_h;
    logic                rel_walk;
    logic [ElapsedW-1:0] countdown;
    logic [ElapsedW-1:0] elapsed;
    logic [2:0]          pending;
    logic [2:0]          phase;
  } signal_state_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_MOSTLY} rx_mode_e;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [0:0]          s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CfgW-1:0]     cfg_wdata_i     = '0;

  actuated_signal_phase_controller u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Controller mirror: timing registers, phase state, tick counter
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0]     ns_min_q   = RstNsMinGreen;
  logic [CfgW-1:0]     ew_min_q   = RstEwMinGreen;
  logic [CfgW-1:0]     max_grn_q  = RstMaxGreen;
  logic [CfgW-1:0]     ns_yel_q   = RstNsYellow;
  logic [CfgW-1:0]     ew_yel_q   = RstEwYellow;
  logic [CfgW-1:0]     red_time_q = RstAllRed;
  logic [CfgW-1:0]     walk_q     = RstWalkTime;
  phase_e              phase_q    = PH_NS_GREEN;
  phase_e              target_q   = PH_NS_GREEN;
  logic [TickBits-1:0] ticks_q    = '0;

  signal_state_t predicted_states[$];
  int unsigned   mismatches = 0;
  int unsigned   burst_left = 0;
  logic          manual_sel = MODE_AUTO;

  function automatic void count_tick_sat();
    if (ticks_q != TickMax) ticks_q = ticks_q + 1'b1;
  endfunction

  function automatic void switch_phase(input phase_e p);
    phase_q = p;
    ticks_q = '0;
  endfunction

  function automatic phase_e busier_axis(input logic [LoadW-1:0] ns, ew, input logic rush);
    if (ns > ew) return PH_NS_GREEN;
    if (ew > ns) return PH_EW_GREEN;
    return rush ? PH_NS_GREEN : PH_EW_GREEN;
  endfunction

  function automatic signal_state_t predict_signal_state(input logic kind,
                                                         input item_fields_t f);
    signal_state_t   r;
    logic            is_ns, past_min, scramble, go_yellow;
    logic [LoadW-1:0] own, other;
    logic [CfgW-1:0] min_g, limit;
    phase_e          grn;
    r = '0;
    if (kind == KIND_TICK) begin
      case (phase_q)
        PH_NS_GREEN, PH_EW_GREEN: begin
          count_tick_sat();
          if (!f.manual) begin
            is_ns    = (phase_q == PH_NS_GREEN);
            own      = is_ns ? f.ns : f.ew;
            other    = is_ns ? f.ew : f.ns;
            min_g    = is_ns ? ns_min_q : ew_min_q;
            past_min = (ticks_q >= min_g);
            scramble = f.wh && f.wv && past_min;
            go_yellow = scramble || (past_min && (other > own || (other != 0 && own == 0) ||
                                                  ticks_q >= max_grn_q));
            if (go_yellow) begin
              switch_phase(is_ns ? PH_NS_YELLOW : PH_EW_YELLOW);
              target_q = scramble ? PH_ALL_WALK : (is_ns ? PH_EW_GREEN : PH_NS_GREEN);
            end
          end
        end
        PH_NS_YELLOW, PH_EW_YELLOW: begin
          count_tick_sat();
          if (ticks_q >= ((phase_q == PH_NS_YELLOW) ? ns_yel_q : ew_yel_q)) begin
            // manual mode skips the clearance when a green is waiting
            if (f.manual && (target_q == PH_NS_GREEN || target_q == PH_EW_GREEN))
              switch_phase(target_q);
            else
              switch_phase(PH_ALL_RED);
          end
        end
        PH_ALL_RED: begin
          count_tick_sat();
          if (target_q != PH_ALL_RED && ticks_q >= red_time_q) begin
            if (target_q == PH_ALL_WALK) begin
              if (f.clr) begin
                switch_phase(PH_ALL_WALK);
                r.rel_walk = 1'b1;
              end
            end else begin
              switch_phase(target_q);
            end
          end
        end
        default: begin
          count_tick_sat();
          if (ticks_q >= walk_q && !f.wh && !f.wv && !f.walkers) begin
            switch_phase(PH_ALL_RED);
            target_q = f.manual ? PH_ALL_RED : busier_axis(f.ns, f.ew, f.rush);
          end
        end
      endcase
    end else begin
      case (f.tgt)
        REQ_WALK_H: r.add_h = 1'b1;
        REQ_WALK_V: r.add_v = 1'b1;
        REQ_ALL_WALK, REQ_ALL_RED: begin
          target_q = (f.tgt == REQ_ALL_WALK) ? PH_ALL_WALK : PH_ALL_RED;
          if (phase_q == PH_NS_GREEN) begin
            switch_phase(PH_NS_YELLOW);
          end else if (phase_q == PH_EW_GREEN) begin
            switch_phase(PH_EW_YELLOW);
          end else if (phase_q == PH_ALL_RED) begin
            if (f.tgt == REQ_ALL_RED) begin
              ticks_q = '0;
            end else if (f.clr) begin
              switch_phase(PH_ALL_WALK);
              r.rel_walk = 1'b1;
            end
          end
        end
        REQ_NS_GREEN, REQ_EW_GREEN: begin
          grn      = (f.tgt == REQ_NS_GREEN) ? PH_NS_GREEN : PH_EW_GREEN;
          target_q = grn;
          if (phase_q == PH_NS_GREEN && grn == PH_EW_GREEN)
            switch_phase(PH_NS_YELLOW);
          else if (phase_q == PH_EW_GREEN && grn == PH_NS_GREEN)
            switch_phase(PH_EW_YELLOW);
          else if (phase_q == PH_ALL_RED)
            switch_phase(grn);
        end
        default: ;
      endcase
    end

    case (phase_q)
      PH_NS_GREEN:  limit = ns_min_q;
      PH_NS_YELLOW: limit = ns_yel_q;
      PH_ALL_RED:   limit = red_time_q;
      PH_EW_GREEN:  limit = ew_min_q;
      PH_EW_YELLOW: limit = ew_yel_q;
      default:      limit = walk_q;
    endcase
    // held phases show no countdown
    if (f.manual && (phase_q == PH_NS_GREEN || phase_q == PH_EW_GREEN ||
                     (phase_q == PH_ALL_RED && target_q == PH_ALL_RED)))
      limit = '0;
    r.countdown = (limit > ticks_q) ? ElapsedW'(limit - ticks_q) : '0;
    r.phase     = phase_q;
    r.pending   = target_q;
    r.elapsed   = ticks_q[ElapsedW-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Mirror update and result check, both on the sampling edge
  always @(posedge clk_i) begin
    signal_state_t want, got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NS_MIN_GREEN: ns_min_q   = cfg_wdata_i;
          CFG_EW_MIN_GREEN: ew_min_q   = cfg_wdata_i;
          CFG_MAX_GREEN:    max_grn_q  = cfg_wdata_i;
          CFG_NS_YELLOW:    ns_yel_q   = cfg_wdata_i;
          CFG_EW_YELLOW:    ew_yel_q   = cfg_wdata_i;
          CFG_ALL_RED:      red_time_q = cfg_wdata_i;
          CFG_WALK_TIME:    walk_q     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        predicted_states.push_back(predict_signal_state(
          s_axis_tuser_i[0], item_fields_t'(s_axis_tdata_i[$bits(item_fields_t)-1:0])));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = signal_state_t'(m_axis_tdata_o[$bits(signal_state_t)-1:0]);
        if (predicted_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %h", m_axis_tdata_o);
        end else begin
          want = predicted_states.pop_front();
          check_field("phase", 32'(want.phase), 32'(got.phase));
          check_field("pending_phase", 32'(want.pending), 32'(got.pending));
          check_field("phase_elapsed", 32'(want.elapsed), 32'(got.elapsed));
          check_field("countdown", 32'(want.countdown), 32'(got.countdown));
          check_field("release_walkers", 32'(want.rel_walk), 32'(got.rel_walk));
          check_field("add_waiter_h", 32'(want.add_h), 32'(got.add_h));
          check_field("add_waiter_v", 32'(want.add_v), 32'(got.add_v));
          check_field("tdata padding", '0,
                      32'(m_axis_tdata_o[OutDataW-1:$bits(signal_state_t)]));
        end
      end
    end
  end

  // Result side backpressure: randomly chosen modes, each held for a random run
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  logic [1:0]  rx_step = '0;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    rx_step++;
    case (rx_mode)
      RX_OPEN:  m_axis_tready_i = 1'b1;
      RX_COIN:  m_axis_tready_i = ($urandom_range(0, 1) == 0);
      RX_SLOW:  m_axis_tready_i = (rx_step == 2'b11);
      default:  m_axis_tready_i = ($urandom_range(0, 7) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_fields_t make_fields(input logic [2:0] tgt, input logic manual,
                                               input logic [LoadW-1:0] ns, ew,
                                               input logic wh, wv, walkers, clr, rush);
    item_fields_t f;
    f.tgt = tgt;      f.manual = manual;   f.ns  = ns;   f.ew   = ew;
    f.wh  = wh;       f.wv     = wv;       f.walkers = walkers;
    f.clr = clr;      f.rush   = rush;
    return f;
  endfunction

  function automatic logic [LoadW-1:0] random_load();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LoadW'($urandom_range(0, (1 << LoadW) - 1));
    endcase
  endfunction

  function automatic item_fields_t random_fields(input logic manual);
    item_fields_t f;
    f.tgt     = 3'($urandom_range(0, 7));
    f.manual  = manual;
    f.ns      = random_load();
    f.ew      = random_load();
    f.wh      = ($urandom_range(0, 4) == 0);
    f.wv      = ($urandom_range(0, 4) == 0);
    f.walkers = ($urandom_range(0, 6) == 0);
    f.clr     = ($urandom_range(0, 3) != 0);
    f.rush    = ($urandom_range(0, 1) == 1);
    return f;
  endfunction

  // One input transfer; the sender runs in bursts separated by random gaps
  task automatic send_item(input logic kind, input item_fields_t f);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = kind;
    s_axis_tdata_i  = {{(InDataW - $bits(item_fields_t)){1'b0}}, f};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Waits for every result, then rewrites all timing registers
  task automatic program_timing(input logic [CfgW-1:0] ns_min, ew_min, max_g,
                                input logic [CfgW-1:0] ns_y, ew_y, red, walk);
    logic [CfgW-1:0] vals [7];
    s_axis_tvalid_i = 1'b0;
    while (predicted_states.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    vals = '{ns_min, ew_min, max_g, ns_y, ew_y, red, walk};
    foreach (vals[i]) begin
      cfg_we_i    = 1'b1;
      cfg_idx_i   = cfg_idx_e'(i);
      cfg_wdata_i = vals[i];
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  task automatic run_random_traffic(input int unsigned count);
    logic kind;
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) manual_sel = ~manual_sel;
      kind = ($urandom_range(0, 99) < 15) ? KIND_REQ : KIND_TICK;
      send_item(kind, random_fields(manual_sel));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '0, '0, 0, 0, 0, 1, 0));
    send_item(KIND_REQ,  make_fields(REQ_WALK_H, MODE_AUTO, '0, '0, 0, 0, 0, 1, 0));
    send_item(KIND_REQ,  make_fields(REQ_WALK_V, MODE_MANUAL, '1, '1, 1, 1, 1, 0, 1));
    send_item(KIND_REQ,  make_fields(REQ_UNUSED, MODE_AUTO, '1, '0, 0, 0, 0, 1, 0));
    send_item(KIND_REQ,  make_fields(REQ_EW_GREEN, MODE_MANUAL, '0, '1, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_MANUAL, '0, '1, 0, 0, 0, 1, 0));
  endtask

  task automatic test_directed_sequences();
    program_timing(12'd2, 12'd2, 12'd4, 12'd1, 12'd1, 12'd1, 12'd2);
    // manual yellow goes straight to the requested green
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_MANUAL, '1, '0, 0, 0, 0, 1, 0));
    // heavier other axis takes over after the minimum
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '1, '0, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '1, '0, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '1, '0, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '1, '0, 0, 0, 0, 1, 0));
    // walkers on both axes force a scramble
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '1, '1, 1, 1, 0, 1, 1));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '1, '1, 1, 1, 0, 1, 1));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '1, '1, 1, 1, 0, 1, 1));
    // crossing not clear holds all red
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, 6'd5, 6'd5, 0, 0, 0, 0, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, 6'd5, 6'd5, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, 6'd5, 6'd5, 0, 0, 1, 1, 0));
    // walk ends, equal loads without the NS rush flag pick EW green
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, 6'd5, 6'd5, 0, 0, 0, 1, 0));
    // held all red, then manual scramble and walk end in manual mode
    send_item(KIND_REQ,  make_fields(REQ_ALL_RED, MODE_MANUAL, '0, '0, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_MANUAL, '0, '0, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_AUTO, '0, '0, 0, 0, 0, 1, 0));
    send_item(KIND_REQ,  make_fields(REQ_ALL_WALK, MODE_MANUAL, '0, '0, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_MANUAL, '0, '0, 0, 0, 0, 1, 0));
    send_item(KIND_TICK, make_fields(REQ_NS_GREEN, MODE_MANUAL, '0, '0, 0, 0, 0, 1, 0));
    send_item(KIND_REQ,  make_fields(REQ_NS_GREEN, MODE_MANUAL, '0, '0, 0, 0, 0, 1, 0));
  endtask

  task automatic test_random_small_timing();
    program_timing(12'd2, 12'd3, 12'd6, 12'd1, 12'd2, 12'd1, 12'd3);
    run_random_traffic(160);
  endtask

  task automatic test_random_zero_timing();
    program_timing('0, '0, '0, '0, '0, '0, '0);
    run_random_traffic(110);
  endtask

  task automatic test_random_varied_timing();
    repeat (3) begin
      program_timing(CfgW'($urandom_range(0, 12)), CfgW'($urandom_range(0, 12)),
                     CfgW'($urandom_range(0, 12)), CfgW'($urandom_range(0, 6)),
                     CfgW'($urandom_range(0, 6)), CfgW'($urandom_range(0, 6)),
                     CfgW'($urandom_range(0, 8)));
      run_random_traffic(90);
    end
  endtask

  // Park in a held all red under ticks in both modes, then leave it by request
  task automatic test_held_all_red();
    item_fields_t f;
    program_timing('1, '1, '1, 12'd1, 12'd1, '1, '0);
    send_item(KIND_REQ, make_fields(REQ_ALL_RED, MODE_MANUAL, '0, '0, 0, 0, 0, 1, 0));
    repeat (30) begin
      f = random_fields(MODE_MANUAL);
      f.wh      = 1'b0;
      f.wv      = 1'b0;
      f.walkers = 1'b0;
      send_item(KIND_TICK, f);
    end
    repeat (20) send_item(KIND_TICK, random_fields(MODE_AUTO));
    send_item(KIND_REQ, make_fields(REQ_EW_GREEN, MODE_AUTO, '0, '1, 0, 0, 0, 1, 1));
  endtask

  task automatic test_random_max_timing();
    program_timing('1, '1, '1, '1, '1, '1, '1);
    run_random_traffic(70);
  endtask

  initial begin
    int unsigned waited;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_directed_sequences();
    test_random_small_timing();
    test_random_zero_timing();
    test_random_varied_timing();
    test_held_all_red();
    test_random_max_timing();
    test_random_small_timing();

    s_axis_tvalid_i = 1'b0;
    waited = 0;
    while (predicted_states.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    if (predicted_states.size() != 0) begin
      $display("%0d results never arrived", predicted_states.size());
      mismatches += predicted_states.size();
    end
    repeat (10) @(negedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
design/aspc_pkg.sv
design/actuated_signal_phase_controller.sv
test/testbench.sv
